[design/swzp_pkg.sv]
// ----------------------------------------------------------------------------
// swzp_pkg
// Types and constants shared by the swap zone placement and victim pick block
// ----------------------------------------------------------------------------
`default_nettype none

package swzp_pkg;

  localparam int ZONE_W      = 5;
  localparam int TABLE_DEPTH = 32;
  localparam int CNT_W       = 20;
  localparam int RECL_W      = 21;
  localparam int PID_W       = 24;
  localparam int DVD_W       = PID_W - 1;
  localparam int STEP_W      = $clog2(DVD_W);
  localparam int FREE_W      = 6;
  localparam int MARK_W      = 6;
  localparam int SIZE_W      = 7;
  localparam int REM_W       = SIZE_W + 1;
  localparam int SLOT_W      = 6;
  localparam int RANK_W      = $clog2(TABLE_DEPTH) + 1;
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 16;
  localparam int OUT_PAD_W   = OUT_DATA_W - ZONE_W - SLOT_W - 2;
  localparam int CFG_IDX_W   = 1;

  localparam logic [MARK_W-1:0] LOW_MARK_RST  = 6'd7;
  localparam logic [MARK_W-1:0] HIGH_MARK_RST = 6'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_MARK  = 1'b0,
    CFG_HIGH_MARK = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_PLACE  = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_ZONE = 1'b0,
    KIND_SLOT = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_COMPARE,
    ST_DECIDE,
    ST_EMIT_ZONE,
    ST_WAIT_MOD
  } state_e;

  typedef struct packed {
    logic accept;
    logic latch_short;
    logic compare;
    logic inc_idx;
    logic load_zone;
    logic load_slot;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pick_now;
    logic last_idx;
    logic chosen;
    logic out_free;
    logic mod_done;
  } dp_status_t;

endpackage

`default_nettype wire

[design/swzp_modulo.sv]
// ----------------------------------------------------------------------------
// swzp_modulo
// Bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module swzp_modulo (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [swzp_pkg::DVD_W-1:0]   dividend_i,
  input  wire logic [swzp_pkg::SIZE_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic [swzp_pkg::SLOT_W-1:0]       rem_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [swzp_pkg::STEP_W-1:0]   cnt_q, cnt_d;
  logic [swzp_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [swzp_pkg::DVD_W-1:0]    dvd_q, dvd_d;
  logic [swzp_pkg::SIZE_W-1:0]   div_q, div_d;
  logic [swzp_pkg::REM_W-1:0]    rem_shift;

  assign rem_shift = {rem_q[swzp_pkg::SIZE_W-1:0], dvd_q[swzp_pkg::DVD_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[swzp_pkg::DVD_W-2:0], 1'b0};
      if (rem_shift >= {1'b0, div_q}) begin
        rem_d = rem_shift - {1'b0, div_q};
      end else begin
        rem_d = rem_shift;
      end
      if (cnt_q == swzp_pkg::STEP_W'(swzp_pkg::DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[swzp_pkg::SLOT_W-1:0];

endmodule

`default_nettype wire

[design/swzp_datapath.sv]
// ----------------------------------------------------------------------------
// swzp_datapath
// Zone status table, per-zone rank compare, request registers and output word
// ----------------------------------------------------------------------------
`default_nettype none

module swzp_datapath #(
  parameter int NUM_ZONES = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire swzp_pkg::ctrl_cmd_t               cmd_i,
  output swzp_pkg::dp_status_t                   status_o,
  input  wire logic [swzp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [swzp_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [swzp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [swzp_pkg::MARK_W-1:0]       cfg_data_i
);

  localparam int LIMIT = (NUM_ZONES < swzp_pkg::TABLE_DEPTH) ? NUM_ZONES
                                                             : swzp_pkg::TABLE_DEPTH;

  // input word fields
  logic [swzp_pkg::ZONE_W-1:0]  in_zone;
  logic                         in_full;
  logic [swzp_pkg::CNT_W-1:0]   in_inv;
  logic [swzp_pkg::CNT_W-1:0]   in_cache;
  logic [swzp_pkg::PID_W-1:0]   in_pid;
  logic [swzp_pkg::FREE_W-1:0]  in_free;
  logic                         in_gc;
  logic [swzp_pkg::SIZE_W-1:0]  in_size;

  assign in_zone  = s_axis_tdata[4:0];
  assign in_full  = s_axis_tdata[5];
  assign in_inv   = s_axis_tdata[25:6];
  assign in_cache = s_axis_tdata[45:26];
  assign in_pid   = s_axis_tdata[69:46];
  assign in_free  = s_axis_tdata[75:70];
  assign in_gc    = s_axis_tdata[76];
  assign in_size  = s_axis_tdata[83:77];

  logic [swzp_pkg::MARK_W-1:0] low_mark_q, high_mark_q;

  logic                        vld_q  [swzp_pkg::TABLE_DEPTH];
  logic                        full_q [swzp_pkg::TABLE_DEPTH];
  logic [swzp_pkg::RECL_W-1:0] recl_q [swzp_pkg::TABLE_DEPTH];

  logic [swzp_pkg::RECL_W-1:0]      val   [swzp_pkg::TABLE_DEPTH];
  logic [swzp_pkg::TABLE_DEPTH-1:0] elig;
  logic [swzp_pkg::TABLE_DEPTH-1:0] beats;
  logic [swzp_pkg::TABLE_DEPTH-1:0] beats_q;
  logic                             cand_elig_q;
  logic [swzp_pkg::ZONE_W-1:0]      idx_q;
  logic [swzp_pkg::MARK_W-1:0]      need_q;
  logic                             short_q;
  logic                             bad_q;
  logic [swzp_pkg::RANK_W-1:0]      rank;
  logic [swzp_pkg::RANK_W-1:0]      elig_cnt;
  logic                             write_zone;

  logic                            out_valid_q;
  logic                            out_kind_q;
  logic [swzp_pkg::ZONE_W-1:0]     out_zone_q;
  logic [swzp_pkg::SLOT_W-1:0]     out_slot_q;
  logic                            out_short_q;
  logic                            out_bad_q;
  logic                            out_last_q;
  logic                            out_free;

  logic                            mod_start;
  logic                            mod_done;
  logic [swzp_pkg::SLOT_W-1:0]     mod_rem;
  logic [swzp_pkg::DVD_W-1:0]      pid_pos;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_mark_q  <= swzp_pkg::LOW_MARK_RST;
      high_mark_q <= swzp_pkg::HIGH_MARK_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        swzp_pkg::CFG_LOW_MARK:  low_mark_q  <= cfg_data_i;
        swzp_pkg::CFG_HIGH_MARK: high_mark_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zone table
  assign write_zone = cmd_i.accept && (s_axis_tuser == swzp_pkg::CMD_UPDATE)
                      && (int'(in_zone) < NUM_ZONES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < swzp_pkg::TABLE_DEPTH; j++) begin
        vld_q[j] <= 1'b0;
      end
    end else if (write_zone) begin
      vld_q[in_zone] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_zone) begin
      full_q[in_zone] <= in_full;
      recl_q[in_zone] <= swzp_pkg::RECL_W'(in_inv) + swzp_pkg::RECL_W'(in_cache);
    end
  end

  always_comb begin
    for (int j = 0; j < swzp_pkg::TABLE_DEPTH; j++) begin
      val[j]  = vld_q[j] ? recl_q[j] : '0;
      elig[j] = (j < LIMIT) && vld_q[j] && full_q[j] && (val[j] != '0);
    end
  end

  // rank of the candidate zone among eligible zones
  always_comb begin
    for (int j = 0; j < swzp_pkg::TABLE_DEPTH; j++) begin
      beats[j] = elig[j] && ((val[j] > val[idx_q]) ||
                 ((val[j] == val[idx_q]) && (swzp_pkg::ZONE_W'(j) < idx_q)));
    end
  end

  assign rank     = swzp_pkg::RANK_W'($countones(beats_q));
  assign elig_cnt = swzp_pkg::RANK_W'($countones(elig));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      short_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        idx_q   <= '0;
        short_q <= 1'b0;
      end else begin
        if (cmd_i.inc_idx) begin
          idx_q <= idx_q + 1'b1;
        end
        if (cmd_i.latch_short) begin
          short_q <= ({1'b0, elig_cnt} < {1'b0, need_q});
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      need_q <= high_mark_q - in_free;
      bad_q  <= (in_size == '0);
    end
    if (cmd_i.compare) begin
      beats_q     <= beats;
      cand_elig_q <= elig[idx_q];
    end
  end

  // slot modulo
  assign mod_start = cmd_i.accept && (s_axis_tuser == swzp_pkg::CMD_PLACE);
  assign pid_pos   = in_pid[swzp_pkg::PID_W-1] ? '0 : in_pid[swzp_pkg::DVD_W-1:0];

  swzp_modulo u_modulo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (pid_pos),
    .divisor_i  (in_size),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // output word register
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_zone || cmd_i.load_slot) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_zone) begin
      out_kind_q  <= swzp_pkg::KIND_ZONE;
      out_zone_q  <= idx_q;
      out_slot_q  <= '0;
      out_short_q <= 1'b0;
      out_bad_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (cmd_i.load_slot) begin
      out_kind_q  <= swzp_pkg::KIND_SLOT;
      out_zone_q  <= '0;
      out_slot_q  <= bad_q ? '0 : mod_rem;
      out_short_q <= short_q;
      out_bad_q   <= bad_q;
      out_last_q  <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{swzp_pkg::OUT_PAD_W{1'b0}}, out_bad_q, out_short_q,
                          out_slot_q, out_zone_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // status to the controller
  assign status_o.pick_now = (in_free < low_mark_q) && !in_gc && (high_mark_q > in_free);
  assign status_o.last_idx = (idx_q == swzp_pkg::ZONE_W'(LIMIT - 1));
  assign status_o.chosen   = cand_elig_q && ({1'b0, rank} < {1'b0, need_q});
  assign status_o.out_free = out_free;
  assign status_o.mod_done = mod_done;

  ap_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_zone || cmd_i.load_slot) |-> out_free)
    else $error("output word overwritten before it was taken");

  ap_zone_is_eligible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_zone |-> cand_elig_q)
    else $error("ineligible zone emitted as victim");

  ap_slot_after_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_slot |-> mod_done)
    else $error("slot word loaded before the remainder was ready");

  ap_last_is_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_kind_q == swzp_pkg::KIND_SLOT))
    else $error("last word is not a slot word");

endmodule

`default_nettype wire

[design/swzp_ctrl.sv]
// ----------------------------------------------------------------------------
// swzp_ctrl
// Controller sequencing updates, victim scan, word emission and slot result
// ----------------------------------------------------------------------------
`default_nettype none

module swzp_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic                  s_axis_tuser,
  input  wire swzp_pkg::dp_status_t  status_i,
  output swzp_pkg::ctrl_cmd_t        cmd_o
);

  swzp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swzp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swzp_pkg::ST_IDLE: begin
        if (s_axis_tvalid && (s_axis_tuser == swzp_pkg::CMD_PLACE)) begin
          state_d = status_i.pick_now ? swzp_pkg::ST_SETUP : swzp_pkg::ST_WAIT_MOD;
        end
      end
      swzp_pkg::ST_SETUP:   state_d = swzp_pkg::ST_COMPARE;
      swzp_pkg::ST_COMPARE: state_d = swzp_pkg::ST_DECIDE;
      swzp_pkg::ST_DECIDE: begin
        priority if (status_i.chosen) begin
          state_d = swzp_pkg::ST_EMIT_ZONE;
        end else if (status_i.last_idx) begin
          state_d = swzp_pkg::ST_WAIT_MOD;
        end else begin
          state_d = swzp_pkg::ST_COMPARE;
        end
      end
      swzp_pkg::ST_EMIT_ZONE: begin
        if (status_i.out_free) begin
          state_d = status_i.last_idx ? swzp_pkg::ST_WAIT_MOD : swzp_pkg::ST_COMPARE;
        end
      end
      swzp_pkg::ST_WAIT_MOD: begin
        if (status_i.mod_done && status_i.out_free) begin
          state_d = swzp_pkg::ST_IDLE;
        end
      end
      default: state_d = swzp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      swzp_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.accept  = s_axis_tvalid;
      end
      swzp_pkg::ST_SETUP: begin
        cmd_o.latch_short = 1'b1;
      end
      swzp_pkg::ST_COMPARE: begin
        cmd_o.compare = 1'b1;
      end
      swzp_pkg::ST_DECIDE: begin
        cmd_o.inc_idx = !status_i.chosen && !status_i.last_idx;
      end
      swzp_pkg::ST_EMIT_ZONE: begin
        cmd_o.load_zone = status_i.out_free;
        cmd_o.inc_idx   = status_i.out_free && !status_i.last_idx;
      end
      swzp_pkg::ST_WAIT_MOD: begin
        cmd_o.load_slot = status_i.mod_done && status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[design/swap_zone_placement_and_gc_pick.sv]
// ----------------------------------------------------------------------------
// swap_zone_placement_and_gc_pick
// Swap zone status table with greedy victim picking and pid slot placement
// ----------------------------------------------------------------------------
// A zone update word is written to the table while the block stays idle. A
// placement request runs the serial remainder unit (one pid bit per cycle)
// and, when victim picking is triggered, walks the first min(NUM_ZONES, 32)
// zones in ascending order, each in a compare state (rank against all zones)
// and a decide state, with an emit state for each victim word. Words that
// are not taken at the output stall the walk. One request is in flight at a
// time.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_zone_placement_and_gc_pick #(
  parameter int NUM_ZONES = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tdata: zone_index, zone_full, invalid_count, cache_count, page_pid,
  //        free_count, gc_busy, slot_count, zero pad
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [swzp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: cmd
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: reclaim_zone, slot, shortage, bad_size, zero pad
  output logic [swzp_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // tuser: result_kind
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [swzp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [swzp_pkg::MARK_W-1:0]       cfg_data_i
);

  swzp_pkg::ctrl_cmd_t  cmd;
  swzp_pkg::dp_status_t status;

  swzp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  swzp_datapath #(
    .NUM_ZONES (NUM_ZONES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

endmodule

`default_nettype wire

[tb/swap_zone_placement_and_gc_pick_test.sv]
// ----------------------------------------------------------------------------
// swap_zone_placement_and_gc_pick_test
// Self-checking bench for the swap zone table, victim pick and slot placement
// ----------------------------------------------------------------------------
// Zone update and placement words are queued by the stimulus process and
// driven over the input stream with random gaps. Each accepted word runs
// through a local model of the zone table and the greedy victim pick, which
// queues the victim and slot words due on the output stream. The monitor
// stalls the output at random and compares every word field by field. The
// low and high marks are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module swap_zone_placement_and_gc_pick_test;

  localparam int ZONE_COUNT   = 32;
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE       = 150;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int GAP_PCT      = 24;

  typedef struct packed {
    swzp_pkg::cmd_e                  cmd;
    logic [swzp_pkg::ZONE_W-1:0]     zone;
    logic                            full;
    logic [swzp_pkg::CNT_W-1:0]      invalid_cnt;
    logic [swzp_pkg::CNT_W-1:0]      cache_cnt;
    logic [swzp_pkg::PID_W-1:0]      pid;
    logic [swzp_pkg::FREE_W-1:0]     free_cnt;
    logic                            gc;
    logic [swzp_pkg::SIZE_W-1:0]     size;
  } zone_word_t;

  typedef struct packed {
    swzp_pkg::kind_e                 kind;
    logic [swzp_pkg::ZONE_W-1:0]     zone;
    logic [swzp_pkg::SLOT_W-1:0]     slot;
    logic                            shortage;
    logic                            bad_size;
    logic                            last;
  } place_result_t;

  typedef struct packed {
    swzp_pkg::cfg_reg_e              idx;
    logic [swzp_pkg::MARK_W-1:0]     value;
  } mark_write_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [swzp_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            s_axis_tuser  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [swzp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [swzp_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [swzp_pkg::MARK_W-1:0]     cfg_data_i    = '0;

  // local copy of the block state
  logic                        zone_is_full [ZONE_COUNT];
  logic [swzp_pkg::RECL_W-1:0] zone_reclaim [ZONE_COUNT];
  logic [swzp_pkg::MARK_W-1:0] low_mark_q  = swzp_pkg::LOW_MARK_RST;
  logic [swzp_pkg::MARK_W-1:0] high_mark_q = swzp_pkg::HIGH_MARK_RST;

  zone_word_t    pending_words [$];
  mark_write_t   mark_writes [$];
  place_result_t victim_slot_fifo [$];
  zone_word_t    cur_word;
  logic          no_gaps = 1'b0;
  int            mismatches = 0;
  int            cycles = 0;

  swap_zone_placement_and_gc_pick #(
    .NUM_ZONES(ZONE_COUNT)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  initial begin
    for (int z = 0; z < ZONE_COUNT; z++) begin
      zone_is_full[z] = 1'b0;
      zone_reclaim[z] = '0;
    end
  end

  // table update, or greedy victim pick followed by the pid slot
  task automatic pick_victims_and_slot(input zone_word_t w);
    logic [ZONE_COUNT-1:0]       taken;
    logic [swzp_pkg::RECL_W-1:0] best;
    int                          best_zone;
    int                          need;
    int                          got;
    int                          z;
    logic                        short_flag;
    int unsigned                 pid_val;
    place_result_t               r;
    if (w.cmd == swzp_pkg::CMD_UPDATE) begin
      zone_is_full[w.zone] = w.full;
      zone_reclaim[w.zone] = swzp_pkg::RECL_W'(w.invalid_cnt)
                             + swzp_pkg::RECL_W'(w.cache_cnt);
    end else begin
      taken = '0;
      short_flag = 1'b0;
      if (w.free_cnt < low_mark_q && !w.gc && high_mark_q > w.free_cnt) begin
        need = int'(high_mark_q) - int'(w.free_cnt);
        got = 0;
        while (got < need && !short_flag) begin
          best = '0;
          best_zone = -1;
          for (z = 0; z < ZONE_COUNT; z++) begin
            if (zone_is_full[z] && !taken[z] && zone_reclaim[z] > best) begin
              best = zone_reclaim[z];
              best_zone = z;
            end
          end
          if (best_zone < 0) begin
            short_flag = 1'b1;
          end else begin
            taken[best_zone] = 1'b1;
            got++;
          end
        end
        for (z = 0; z < ZONE_COUNT; z++) begin
          if (taken[z]) begin
            r = '{kind: swzp_pkg::KIND_ZONE, zone: swzp_pkg::ZONE_W'(z), slot: '0,
                  shortage: 1'b0, bad_size: 1'b0, last: 1'b0};
            victim_slot_fifo.push_back(r);
          end
        end
      end
      r = '{kind: swzp_pkg::KIND_SLOT, zone: '0, slot: '0,
            shortage: short_flag, bad_size: 1'b0, last: 1'b1};
      if (w.size == 0) begin
        r.bad_size = 1'b1;
      end else begin
        pid_val = w.pid[swzp_pkg::PID_W-1] ? 0 : int'(w.pid);
        r.slot = swzp_pkg::SLOT_W'(pid_val % int'(w.size));
      end
      victim_slot_fifo.push_back(r);
    end
  endtask

  // input stream driver
  always @(posedge clk_i) begin
    logic slot_free;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pick_victims_and_slot(cur_word);
      end
      slot_free = !s_axis_tvalid || s_axis_tready;
      if (slot_free) begin
        if (pending_words.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
          cur_word = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_word.cmd;
          s_axis_tdata  <= {4'b0, cur_word.size, cur_word.gc, cur_word.free_cnt,
                            cur_word.pid, cur_word.cache_cnt, cur_word.invalid_cnt,
                            cur_word.full, cur_word.zone};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // mark register writes
  always @(posedge clk_i) begin
    mark_write_t wr;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == swzp_pkg::CFG_LOW_MARK) begin
          low_mark_q = cfg_data_i;
        end else begin
          high_mark_q = cfg_data_i;
        end
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (mark_writes.size() != 0) begin
          wr = mark_writes.pop_front();
          cfg_valid_i <= 1'b1;
          cfg_index_i <= wr.idx;
          cfg_data_i  <= wr.value;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // output stream monitor
  always @(posedge clk_i) begin
    place_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (victim_slot_fifo.size() == 0) begin
          $error("output word with none due: tdata %h tuser %b tlast %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = victim_slot_fifo.pop_front();
          check_field("result_kind", want.kind, m_axis_tuser);
          check_field("reclaim_zone", want.zone, m_axis_tdata[swzp_pkg::ZONE_W-1:0]);
          check_field("slot", want.slot, m_axis_tdata[swzp_pkg::ZONE_W +: swzp_pkg::SLOT_W]);
          check_field("shortage", want.shortage,
                      m_axis_tdata[swzp_pkg::ZONE_W+swzp_pkg::SLOT_W]);
          check_field("bad_size", want.bad_size,
                      m_axis_tdata[swzp_pkg::ZONE_W+swzp_pkg::SLOT_W+1]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      m_axis_tready <= no_gaps || $urandom_range(99) >= GAP_PCT;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic zone_word_t random_word();
    zone_word_t w;
    w.cmd         = swzp_pkg::cmd_e'($urandom_range(1));
    w.zone        = swzp_pkg::ZONE_W'($urandom);
    w.full        = 1'($urandom);
    w.invalid_cnt = swzp_pkg::CNT_W'($urandom);
    w.cache_cnt   = swzp_pkg::CNT_W'($urandom);
    w.pid         = swzp_pkg::PID_W'($urandom);
    w.free_cnt    = swzp_pkg::FREE_W'($urandom);
    w.gc          = 1'($urandom);
    w.size        = swzp_pkg::SIZE_W'($urandom);
    return w;
  endfunction

  task automatic push_update(input int zone, input logic full, input int inv, input int cache);
    zone_word_t w;
    w = random_word();
    w.cmd = swzp_pkg::CMD_UPDATE;
    w.zone = swzp_pkg::ZONE_W'(zone);
    w.full = full;
    w.invalid_cnt = swzp_pkg::CNT_W'(inv);
    w.cache_cnt = swzp_pkg::CNT_W'(cache);
    pending_words.push_back(w);
  endtask

  task automatic push_place(input int pid, input int free_cnt, input logic gc, input int size);
    zone_word_t w;
    w = random_word();
    w.cmd = swzp_pkg::CMD_PLACE;
    w.pid = swzp_pkg::PID_W'(pid);
    w.free_cnt = swzp_pkg::FREE_W'(free_cnt);
    w.gc = gc;
    w.size = swzp_pkg::SIZE_W'(size);
    pending_words.push_back(w);
  endtask

  function automatic int random_count();
    int r;
    r = $urandom_range(9);
    if (r < 5) return $urandom_range(15);
    if (r < 8) return $urandom_range(20'hFFFFF);
    if (r == 8) return 20'hFFFFF;
    return 0;
  endfunction

  task automatic push_random(input int low);
    int pid;
    int free_cnt;
    int size;
    int r;
    if ($urandom_range(99) < 55) begin
      push_update($urandom_range(ZONE_COUNT - 1), $urandom_range(99) < 75,
                  random_count(), random_count());
    end else begin
      r = $urandom_range(9);
      if (r < 2) pid = 24'h800000 | $urandom_range(24'h7FFFFF);
      else if (r == 2) pid = ($urandom_range(1) == 0) ? 24'h7FFFFF : $urandom_range(1);
      else pid = $urandom_range(24'h7FFFFF);
      r = $urandom_range(9);
      if (r == 0) size = 0;
      else if (r == 1) size = $urandom_range(127, 65);
      else size = $urandom_range(64, 1);
      if (low > 0 && $urandom_range(99) < 80) free_cnt = $urandom_range(low - 1);
      else free_cnt = $urandom_range(63);
      push_place(pid, free_cnt, $urandom_range(99) < 15, size);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || s_axis_tvalid || victim_slot_fifo.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic run_phase(input int low, input int high, input int count, input logic quiet);
    mark_writes.push_back('{idx: swzp_pkg::CFG_LOW_MARK,
                            value: swzp_pkg::MARK_W'(low)});
    mark_writes.push_back('{idx: swzp_pkg::CFG_HIGH_MARK,
                            value: swzp_pkg::MARK_W'(high)});
    do @(negedge clk_i);
    while (mark_writes.size() != 0 || cfg_valid_i);
    no_gaps = quiet;
    // hold off halfway until every due word is out
    for (int i = 0; i < count / 2; i++) push_random(low);
    wait_drained();
    for (int i = count / 2; i < count; i++) push_random(low);
    wait_drained();
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table, zero size
    push_place(12345, 0, 1'b0, 0);
    push_update(0, 1'b1, 20'hFFFFF, 20'hFFFFF);
    push_update(31, 1'b1, 10, 0);
    push_update(3, 1'b1, 4, 6);
    push_update(7, 1'b1, 0, 10);
    push_update(9, 1'b1, 0, 0);
    push_update(12, 1'b0, 500, 500);
    push_update(20, 1'b1, 8, 0);
    push_place(24'h7FFFFF, 6, 1'b0, 64);
    push_place(24'hFFFFFF, 6, 1'b1, 127);
    push_place(24'h800000, 7, 1'b0, 1);
    push_place(24'h400000, 63, 1'b0, 65);
    push_place(100, 0, 1'b0, 127);
    push_update(0, 1'b0, 1, 1);
    push_place(77, 5, 1'b0, 7);
    push_update(5, 1'b1, 20'hFFFFF, 0);
    push_update(6, 1'b1, 0, 20'hFFFFF);
    // ties at equal counts go to the lowest index
    push_place(63, 6, 1'b0, 64);
    push_place(0, 0, 1'b0, 64);
    wait_drained();

    run_phase(7, 10, 90, 1'b0);
    run_phase(63, 63, 70, 1'b0);
    run_phase(0, 0, 30, 1'b0);
    run_phase(32, 0, 30, 1'b0);
    run_phase(20, 32, 90, 1'b1);
    run_phase(5, 8, 50, 1'b0);

    if (mismatches == 0 && victim_slot_fifo.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
